// ===== src/stsg_pkg.sv =====
`default_nettype none
package stsg_pkg;

   // build options
   localparam int MAX_CHANNELS    = 8;
   localparam int SINE_TABLE_BITS = 10;
   localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
   localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
   localparam int QUARTER_SIZE    = 1 << QTR_BITS;

   // field widths
   localparam int RATE_BITS      = 18;
   localparam int CHAN_BITS      = 4;
   localparam int SAMPLE_BITS    = 16;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = RATE_BITS;
   localparam int BYTE_IDX_BITS  = $clog2(2 * MAX_CHANNELS);

   // shared divider: one quotient bit per step, dividend holds one extra bit for phase + freq
   localparam int DIV_BITS  = RATE_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_RATE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TONE_FREQUENCY = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_COUNT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIGNED         = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIG_ENDIAN     = 3'd5;

   // sample width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;

   // register reset values
   localparam logic [RATE_BITS-1:0] RST_SAMPLE_RATE    = 18'd48000;
   localparam logic [RATE_BITS-1:0] RST_TONE_FREQUENCY = 18'd1000;
   localparam logic [CHAN_BITS-1:0] RST_CHANNEL_COUNT  = 4'd2;
   localparam logic [1:0]           RST_SAMPLE_WIDTH   = WIDTH_16;

   // pi/2 in Q30
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_GO,
      ST_ACC_RUN,
      ST_NXT_GO,
      ST_NXT_RUN,
      ST_ADR_GO,
      ST_ADR_RUN,
      ST_FMT,
      ST_EMIT
   } stsg_state_type;

   typedef struct packed {
      logic                 start;
      logic [RATE_BITS-1:0] rem_init;
      logic [DIV_BITS-1:0]  dividend;
      logic [RATE_BITS-1:0] divisor;
      logic [STEP_BITS-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [RATE_BITS-1:0] rem;
      logic [DIV_BITS-1:0]  quo;
   } div_rsp_type;

   typedef struct packed {
      logic [1:0] width_sel;
      logic       signed_samples;
      logic       big_endian;
   } fmt_cfg_type;

   typedef struct packed {
      logic       two_byte;
      logic [7:0] first;
      logic [7:0] second;
   } fmt_bytes_type;

   typedef logic [TABLE_SIZE-1:0][SAMPLE_BITS-1:0] sine_rom_type;

   // round(32767 * sin(m * (pi/2) / QUARTER_SIZE)), Q30 Taylor series to x^15
   function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input logic [QTR_BITS:0] m);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'(m) * Q30_HALF_PI) >> QTR_BITS;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if (n[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // full table from the quarter wave by symmetry
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type                rom;
      logic [SINE_TABLE_BITS-1:0]  kb;
      logic [1:0]                  quad;
      logic [QTR_BITS:0]           r;
      logic [QTR_BITS:0]           m;
      logic [SAMPLE_BITS-1:0]      val;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         kb   = SINE_TABLE_BITS'(k);
         quad = kb[SINE_TABLE_BITS-1 -: 2];
         r    = {1'b0, kb[QTR_BITS-1:0]};
         m    = quad[0] ? (QTR_BITS + 1)'(QUARTER_SIZE) - r : r;
         val  = quarter_sine(m);
         if (quad[1]) begin
            val = SAMPLE_BITS'(0) - val;
         end
         rom[k] = val;
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

// ===== src/stsg_divider.sv =====
`default_nettype none
module stsg_divider import stsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [RATE_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0]  shf_ff, shf_in;
   logic [RATE_BITS-1:0] div_ff, div_in;
   logic [RATE_BITS:0]   trial;
   logic                 fits;

   // one restoring step per cycle, quotient bits shift in from the bottom
   always_comb begin
      trial   = {rem_ff, shf_ff[DIV_BITS-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = div_req.rem_init;
         shf_in  = div_req.dividend;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? RATE_BITS'(trial - {1'b0, div_ff}) : trial[RATE_BITS-1:0];
         shf_in = {shf_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      div_ff <= div_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;
   assign div_rsp.quo  = shf_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule
`default_nettype wire

// ===== src/stsg_sine_rom.sv =====
`default_nettype none
module stsg_sine_rom import stsg_pkg::*; (
   input  logic                       clock,
   input  logic [SINE_TABLE_BITS-1:0] rd_addr,
   output logic [SAMPLE_BITS-1:0]     rd_data_ff
);

   localparam sine_rom_type ROM_DATA = build_sine_rom();

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= ROM_DATA[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/stsg_formatter.sv =====
`default_nettype none
module stsg_formatter import stsg_pkg::*; (
   input  logic [SAMPLE_BITS-1:0] sample,
   input  fmt_cfg_type            cfg,
   output fmt_bytes_type          fmt_out
);

   // floor(num / 32767) for num below 255 * 32768, one correction step
   function automatic logic [7:0] div_by_32767(input logic [22:0] num);
      logic [7:0]  q0;
      logic [15:0] r;
      q0 = num[22:15];
      r  = {1'b0, num[14:0]} + {8'd0, q0};
      return q0 + 8'(r >= 16'd32767);
   endfunction

   logic                   neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [22:0]            prod_s;
   logic [7:0]             q_s;
   logic [7:0]             byte_s;
   logic [SAMPLE_BITS-1:0] ofs;
   logic [23:0]            prod_u;
   logic [7:0]             q_u;
   logic [7:0]             byte8;
   logic [SAMPLE_BITS-1:0] word;
   logic                   wide;

   always_comb begin
      // eight-bit signed: magnitude scaled by 127/32767, toward zero
      neg    = sample[SAMPLE_BITS-1];
      mag    = neg ? SAMPLE_BITS'(0) - sample : sample;
      prod_s = 23'(mag) * 23'd127;
      q_s    = div_by_32767(prod_s);
      byte_s = neg ? 8'd0 - q_s : q_s;
      // eight-bit offset: (v + 32767) * 255 / 65534
      ofs    = sample + SAMPLE_BITS'(32767);
      prod_u = 24'(ofs) * 24'd255;
      q_u    = div_by_32767(prod_u[23:1]);
      byte8  = cfg.signed_samples ? byte_s : q_u;
      // sixteen-bit offset: only the top code rounds up
      word   = cfg.signed_samples ? sample
             : ofs + SAMPLE_BITS'(ofs == SAMPLE_BITS'(65534));
      wide   = cfg.width_sel == WIDTH_16;
      fmt_out.two_byte = wide;
      if (wide) begin
         fmt_out.first  = cfg.big_endian ? word[15:8] : word[7:0];
         fmt_out.second = cfg.big_endian ? word[7:0] : word[15:8];
      end else begin
         fmt_out.first  = byte8;
         fmt_out.second = 8'd0;
      end
   end

endmodule
`default_nettype wire

// ===== src/sine_tone_sample_generator.sv =====
`default_nettype none
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_frame_request
// rsp       out        rsp_valid / rsp_ready   rsp_data_byte, rsp_last_of_frame
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// a frame request runs three passes of the serial divider (phase mod rate, next phase
// mod rate, table address) of 18 + 19 + SINE_TABLE_BITS steps, each begun in a GO state,
// then the ROM read and format state ST_FMT before the first byte
// bytes then leave one per cycle while rsp_ready is high, up to 2 * MAX_CHANNELS
// req_ready is high only while idle; a request with frame_request low is dropped
// reset is synchronous and restores the phase and all registers; the ROM needs no fill
module sine_tone_sample_generator import stsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_frame_request,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   stsg_state_type state_ff, state_in;

   logic [RATE_BITS-1:0]     rate_ff, rate_in;
   logic [RATE_BITS-1:0]     freq_ff, freq_in;
   logic [CHAN_BITS-1:0]     chan_ff, chan_in;
   logic [1:0]               width_ff, width_in;
   logic                     signed_ff, signed_in;
   logic                     big_ff, big_in;
   logic [RATE_BITS-1:0]     acc_ff, acc_in;
   logic [RATE_BITS-1:0]     phase_ff, phase_in;
   logic [7:0]               byte0_ff, byte0_in;
   logic [7:0]               byte1_ff, byte1_in;
   logic                     two_ff, two_in;
   logic [BYTE_IDX_BITS-1:0] idx_ff, idx_in;
   logic [BYTE_IDX_BITS-1:0] last_ff, last_in;

   logic [RATE_BITS-1:0]   rate_eff;
   logic [CHAN_BITS-1:0]   chans;
   logic                   width_ok;
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   logic [SAMPLE_BITS-1:0] rom_data;
   fmt_cfg_type            fmt_cfg;
   fmt_bytes_type          fmt_out;

   // effective settings
   assign rate_eff = (rate_ff == '0) ? RATE_BITS'(1) : rate_ff;
   assign width_ok = (width_ff == WIDTH_8) || (width_ff == WIDTH_16);
   always_comb begin
      if (chan_ff == '0) begin
         chans = CHAN_BITS'(1);
      end else if (chan_ff > CHAN_BITS'(MAX_CHANNELS)) begin
         chans = CHAN_BITS'(MAX_CHANNELS);
      end else begin
         chans = chan_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_frame_request) begin
               state_in = ST_ACC_GO;
            end
         end
         ST_ACC_GO:  state_in = ST_ACC_RUN;
         ST_ACC_RUN: begin
            if (div_rsp.done) begin
               state_in = ST_NXT_GO;
            end
         end
         ST_NXT_GO:  state_in = ST_NXT_RUN;
         ST_NXT_RUN: begin
            if (div_rsp.done) begin
               state_in = width_ok ? ST_ADR_GO : ST_IDLE;
            end
         end
         ST_ADR_GO:  state_in = ST_ADR_RUN;
         ST_ADR_RUN: begin
            if (div_rsp.done) begin
               state_in = ST_FMT;
            end
         end
         ST_FMT:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_ready && (idx_ff == last_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshakes and divider requests
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.dividend = {acc_ff, 1'b0};
      div_req.divisor  = rate_eff;
      div_req.steps    = STEP_BITS'(RATE_BITS);
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_ACC_GO: div_req.start = 1'b1;
         ST_NXT_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, phase_ff} + {1'b0, freq_ff};
            div_req.steps    = STEP_BITS'(DIV_BITS);
         end
         ST_ADR_GO: begin
            div_req.start    = 1'b1;
            div_req.rem_init = phase_ff;
            div_req.dividend = '0;
            div_req.steps    = STEP_BITS'(SINE_TABLE_BITS);
         end
         ST_EMIT:   rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   assign csr_ready         = 1'b1;
   assign rsp_data_byte     = (two_ff && idx_ff[0]) ? byte1_ff : byte0_ff;
   assign rsp_last_of_frame = idx_ff == last_ff;

   // configuration writes
   always_comb begin
      rate_in   = rate_ff;
      freq_in   = freq_ff;
      chan_in   = chan_ff;
      width_in  = width_ff;
      signed_in = signed_ff;
      big_in    = big_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE:    rate_in   = csr_data;
            CSR_TONE_FREQUENCY: freq_in   = csr_data;
            CSR_CHANNEL_COUNT:  chan_in   = csr_data[CHAN_BITS-1:0];
            CSR_SAMPLE_WIDTH:   width_in  = csr_data[1:0];
            CSR_SIGNED:         signed_in = csr_data[0];
            CSR_BIG_ENDIAN:     big_in    = csr_data[0];
            default:            ;
         endcase
      end
   end

   // phase, formatted bytes and byte counter
   always_comb begin
      acc_in   = acc_ff;
      phase_in = phase_ff;
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      two_in   = two_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      if ((state_ff == ST_ACC_RUN) && div_rsp.done) begin
         phase_in = div_rsp.rem;
      end
      if ((state_ff == ST_NXT_RUN) && div_rsp.done) begin
         acc_in = div_rsp.rem;
      end
      if (state_ff == ST_FMT) begin
         byte0_in = fmt_out.first;
         byte1_in = fmt_out.second;
         two_in   = fmt_out.two_byte;
         idx_in   = '0;
         last_in  = BYTE_IDX_BITS'(({1'b0, chans} << fmt_out.two_byte) - 5'd1);
      end
      if ((state_ff == ST_EMIT) && rsp_ready) begin
         idx_in = idx_ff + BYTE_IDX_BITS'(1);
      end
   end

   // control and settings
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rate_ff   <= RST_SAMPLE_RATE;
         freq_ff   <= RST_TONE_FREQUENCY;
         chan_ff   <= RST_CHANNEL_COUNT;
         width_ff  <= RST_SAMPLE_WIDTH;
         signed_ff <= 1'b1;
         big_ff    <= 1'b0;
         acc_ff    <= '0;
         idx_ff    <= '0;
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rate_ff   <= rate_in;
         freq_ff   <= freq_in;
         chan_ff   <= chan_in;
         width_ff  <= width_in;
         signed_ff <= signed_in;
         big_ff    <= big_in;
         acc_ff    <= acc_in;
         idx_ff    <= idx_in;
         last_ff   <= last_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      two_ff   <= two_in;
   end

   stsg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   stsg_sine_rom u_sine_rom (
      .clock      (clock),
      .rd_addr    (div_rsp.quo[SINE_TABLE_BITS-1:0]),
      .rd_data_ff (rom_data)
   );

   assign fmt_cfg.width_sel      = width_ff;
   assign fmt_cfg.signed_samples = signed_ff;
   assign fmt_cfg.big_endian     = big_ff;

   stsg_formatter u_formatter (
      .sample  (rom_data),
      .cfg     (fmt_cfg),
      .fmt_out (fmt_out)
   );

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_frame) |=> req_ready)
      else $error("block not idle after last byte of frame");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADR_GO) |-> (phase_ff < rate_eff))
      else $error("phase not reduced below sample rate");

   a_no_accept_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while frame bytes pending");

endmodule
`default_nettype wire

// ===== verif/stsg_frame_checker.sv =====
`timescale 1ns / 1ps
module stsg_frame_checker import stsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_frame_request,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [7:0]               rsp_data_byte,
   input  logic                     rsp_last_of_frame,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       bytes_pending,
   output int                       mismatch_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } pcm_byte_type;

   // sine wave ROM image and shadow copies of the registers and phase
   logic [SAMPLE_BITS-1:0] wave_rom [TABLE_SIZE];
   logic [RATE_BITS-1:0]   cfg_rate;
   logic [RATE_BITS-1:0]   cfg_freq;
   logic [CHAN_BITS-1:0]   cfg_channels;
   logic [1:0]             cfg_width;
   logic                   cfg_signed;
   logic                   cfg_big_endian;
   logic [RATE_BITS-1:0]   phase_acc;
   pcm_byte_type           expected_bytes [$];
   pcm_byte_type           want;
   int                     fail_total = 0;

   // quarter-wave series in Q30, mirrored into the full period
   initial begin
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] rounded;
      int          quad;
      int          r;
      int          m;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         quad = k >> QTR_BITS;
         r    = k & (QUARTER_SIZE - 1);
         m    = quad[0] ? QUARTER_SIZE - r : r;
         x    = (64'(m) * Q30_HALF_PI) / 64'(QUARTER_SIZE);
         term = x;
         acc  = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
               acc = acc + term;
            end
         end
         rounded = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
         if (rounded > 64'd32767) begin
            rounded = 64'd32767;
         end
         wave_rom[k] = (quad >= 2) ? SAMPLE_BITS'(64'd0 - rounded) : SAMPLE_BITS'(rounded);
      end
   end

   // advance the phase and queue the bytes of one frame
   task automatic predict_frame();
      logic [63:0] divisor;
      logic [63:0] cur_phase;
      logic [63:0] addr;
      logic [15:0] word;
      logic [7:0]  first;
      logic [7:0]  second;
      int          sv;
      int          mag;
      int          n_ch;
      bit          two_bytes;
      divisor   = (cfg_rate == '0) ? 64'd1 : 64'(cfg_rate);
      cur_phase = 64'(phase_acc) % divisor;
      phase_acc = RATE_BITS'((cur_phase + 64'(cfg_freq)) % divisor);
      addr      = ((cur_phase << SINE_TABLE_BITS) / divisor) & 64'(TABLE_SIZE - 1);
      sv        = int'($signed(wave_rom[addr]));
      first     = '0;
      second    = '0;
      case (cfg_width)
         WIDTH_8: begin
            two_bytes = 1'b0;
            if (cfg_signed) begin
               mag   = ((sv < 0) ? -sv : sv) * 127 / 32767;
               first = (sv < 0) ? 8'(256 - mag) : 8'(mag);
            end else begin
               first = 8'((sv + 32767) * 255 / 65534);
            end
         end
         WIDTH_16: begin
            two_bytes = 1'b1;
            if (cfg_signed) begin
               word = 16'(sv);
            end else begin
               word = 16'((longint'(sv + 32767) * 65535) / 65534);
            end
            if (cfg_big_endian) begin
               first  = word[15:8];
               second = word[7:0];
            end else begin
               first  = word[7:0];
               second = word[15:8];
            end
         end
         // unsupported sizes: phase moves, nothing is sent
         default: return;
      endcase
      n_ch = (cfg_channels == '0) ? 1 :
             (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_channels);
      for (int c = 0; c < n_ch; c++) begin
         expected_bytes.push_back('{first, !two_bytes && c == n_ch - 1});
         if (two_bytes) begin
            expected_bytes.push_back('{second, c == n_ch - 1});
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_rate       = RST_SAMPLE_RATE;
         cfg_freq       = RST_TONE_FREQUENCY;
         cfg_channels   = RST_CHANNEL_COUNT;
         cfg_width      = RST_SAMPLE_WIDTH;
         cfg_signed     = 1'b1;
         cfg_big_endian = 1'b0;
         phase_acc      = '0;
         expected_bytes.delete();
      end else begin
         // register write transaction
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_RATE:    cfg_rate       = csr_data[RATE_BITS-1:0];
               CSR_TONE_FREQUENCY: cfg_freq       = csr_data[RATE_BITS-1:0];
               CSR_CHANNEL_COUNT:  cfg_channels   = csr_data[CHAN_BITS-1:0];
               CSR_SAMPLE_WIDTH:   cfg_width      = csr_data[1:0];
               CSR_SIGNED:         cfg_signed     = csr_data[0];
               CSR_BIG_ENDIAN:     cfg_big_endian = csr_data[0];
               default: ;
            endcase
         end
         // request transaction, idle requests are dropped
         if (req_valid && req_ready && req_frame_request) begin
            predict_frame();
         end
         // byte transaction against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("%0t: unexpected pcm byte %02h last %0b", $time,
                           rsp_data_byte, rsp_last_of_frame);
               end
            end else begin
               want = expected_bytes.pop_front();
               if (want.data_byte !== rsp_data_byte || want.last !== rsp_last_of_frame) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("%0t: pcm byte mismatch, expected %02h last %0b, got %02h last %0b",
                              $time, want.data_byte, want.last, rsp_data_byte,
                              rsp_last_of_frame);
                  end
               end
            end
         end
      end
      bytes_pending  <= expected_bytes.size();
      mismatch_count <= fail_total;
   end

endmodule

// ===== verif/tb_sine_tone_sample_generator.sv =====
`timescale 1ns / 1ps
module tb_sine_tone_sample_generator;
   import stsg_pkg::*;

   localparam int          RANDOM_FRAMES     = 205;
   localparam int          DRAIN_CYCLES      = 80;
   localparam int          WATCHDOG_LIMIT    = 2000;
   localparam logic [1:0]  WIDTH_UNSUPPORTED = 2'd2;
   localparam logic [1:0]  WIDTH_RESERVED    = 2'd3;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic                     req_frame_request = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic [7:0]               rsp_data_byte;
   logic                     rsp_last_of_frame;
   logic                     csr_valid         = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index         = CSR_SAMPLE_RATE;
   logic [CSR_DATA_BITS-1:0] csr_data          = '0;

   int bytes_pending;
   int mismatch_count;
   int frames_requested = 0;
   int idle_requests    = 0;
   int csr_writes       = 0;
   int settings_applied = 0;
   int bytes_seen       = 0;
   int stall_left       = 0;
   int next_stall       = 0;
   int quiet_cycles     = 0;
   bit byte_taken       = 1'b0;
   bit sender_relaxed   = 1'b0;
   bit ready_steady     = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   sine_tone_sample_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_request (req_frame_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   stsg_frame_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_request (req_frame_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .bytes_pending     (bytes_pending),
      .mismatch_count    (mismatch_count)
   );

   // one request transaction after a random gap
   task automatic send_request(input logic want_frame);
      int gap;
      gap = sender_relaxed ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_request <= want_frame;
      do @(posedge clock); while (!req_ready);
      if (want_frame) begin
         frames_requested++;
      end else begin
         idle_requests++;
      end
   endtask

   // drop the request line and let every queued byte drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   // narrow registers sometimes get junk above their width
   function automatic logic [CSR_DATA_BITS-1:0] pad_upper(input logic [CSR_DATA_BITS-1:0] value,
                                                          input int width);
      logic [CSR_DATA_BITS-1:0] keep;
      keep = (CSR_DATA_BITS'(1) << width) - 1'b1;
      if ($urandom_range(0, 3) == 0) begin
         return (CSR_DATA_BITS'($urandom) & ~keep) | (value & keep);
      end
      return value & keep;
   endfunction

   task automatic apply_settings(input logic [RATE_BITS-1:0] rate,
                                 input logic [RATE_BITS-1:0] freq,
                                 input logic [CHAN_BITS-1:0] chans,
                                 input logic [1:0]           wsel,
                                 input logic                 sgn,
                                 input logic                 be);
      wait_idle();
      csr_write(CSR_SAMPLE_RATE, rate);
      csr_write(CSR_TONE_FREQUENCY, freq);
      csr_write(CSR_CHANNEL_COUNT, pad_upper(CSR_DATA_BITS'(chans), CHAN_BITS));
      csr_write(CSR_SAMPLE_WIDTH, pad_upper(CSR_DATA_BITS'(wsel), 2));
      csr_write(CSR_SIGNED, pad_upper(CSR_DATA_BITS'(sgn), 1));
      csr_write(CSR_BIG_ENDIAN, pad_upper(CSR_DATA_BITS'(be), 1));
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // byte sink with random back-pressure, steady stretches now and then
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (byte_taken && next_stall > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= next_stall - 1;
      end else if (!byte_taken && stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end
   end

   // draw the wait after each byte transaction
   always @(posedge clock) begin
      byte_taken <= rsp_valid && rsp_ready;
      if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 29) == 0) begin
            ready_steady <= !ready_steady;
         end
         next_stall <= ready_steady ? 0 : int'($urandom_range(0, 10));
         bytes_seen <= bytes_seen + 1;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("tb_sine_tone_sample_generator NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int                   frames_left;
      int                   phase_len;
      int                   pick;
      logic [RATE_BITS-1:0] rate;
      logic [RATE_BITS-1:0] freq;
      logic [CHAN_BITS-1:0] chans;
      logic [1:0]           wsel;
      logic                 sgn;
      logic                 be;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset settings with idle requests mixed in
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      // quarter points of the wave: zero, peak, zero, trough
      apply_settings(4, 1, 1, WIDTH_8, 1'b0, 1'b0);
      repeat (4) send_request(1'b1);
      apply_settings(4, 1, 1, WIDTH_8, 1'b1, 1'b0);
      repeat (4) send_request(1'b1);
      apply_settings(4, 1, 8, WIDTH_16, 1'b0, 1'b1);
      repeat (4) send_request(1'b1);
      // zero rate pins the phase at zero, zero channels acts as one
      apply_settings(0, 777, 0, WIDTH_16, 1'b1, 1'b0);
      repeat (2) send_request(1'b1);
      // no bytes for unsupported sizes, here with a channel count above the maximum
      apply_settings(48000, 12345, 15, WIDTH_RESERVED, 1'b1, 1'b1);
      repeat (2) send_request(1'b1);
      apply_settings(48000, 12345, 15, WIDTH_UNSUPPORTED, 1'b0, 1'b0);
      send_request(1'b1);
      // widest rate with a large frequency, then a rate below the running phase
      apply_settings(262143, 192000, 9, WIDTH_16, 1'b1, 1'b1);
      repeat (2) send_request(1'b1);
      apply_settings(5, 3, 3, WIDTH_8, 1'b1, 1'b0);
      repeat (2) send_request(1'b1);

      // random settings, each held for a run of requests
      frames_left = RANDOM_FRAMES;
      while (frames_left > 0) begin
         case ($urandom_range(0, 9))
            0:       rate = '0;
            1:       rate = 1;
            2:       rate = '1;
            3:       rate = RATE_BITS'($urandom_range(1, 64));
            default: rate = RATE_BITS'($urandom_range(1, 192000));
         endcase
         case ($urandom_range(0, 7))
            0:       freq = '0;
            1:       freq = RATE_BITS'($urandom_range(0, 262143));
            2:       freq = rate;
            default: freq = RATE_BITS'($urandom_range(0, 20000));
         endcase
         chans = ($urandom_range(0, 3) == 0) ? CHAN_BITS'($urandom_range(0, 15))
                                              : CHAN_BITS'($urandom_range(1, 8));
         pick  = $urandom_range(0, 9);
         wsel  = (pick < 4) ? WIDTH_8 : (pick < 8) ? WIDTH_16 :
                 (pick == 8) ? WIDTH_UNSUPPORTED : WIDTH_RESERVED;
         sgn   = 1'($urandom_range(0, 1));
         be    = 1'($urandom_range(0, 1));
         apply_settings(rate, freq, chans, wsel, sgn, be);
         sender_relaxed = ($urandom_range(0, 3) == 0);
         phase_len      = $urandom_range(8, 30);
         repeat (phase_len) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(1'b0);
            end else begin
               send_request(1'b1);
               frames_left--;
            end
         end
      end

      wait_idle();
      $display("covered %0d frame requests and %0d idle requests over %0d register settings",
               frames_requested, idle_requests, settings_applied + 1);
      $display("%0d pcm bytes checked after %0d register writes", bytes_seen, csr_writes);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("tb_sine_tone_sample_generator OK");
      end else begin
         $display("%0d mismatches, %0d bytes still expected", mismatch_count, bytes_pending);
         $display("tb_sine_tone_sample_generator NOT OK");
      end
      $finish;
   end

endmodule
